[rtl/core/fpsqrt_pkg.sv]
package fpsqrt_pkg;

  // default radicand format: signed Q16.16
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // root field width, unsigned
  localparam int ROOT_W = 24;

  // root bits resolved per pipeline stage
  localparam int BITS_PER_STAGE = 2;

endpackage

[rtl/core/fixed_point_square_root_top.sv]
// Channel | Dir | Transaction payload
// --------+-----+--------------------------------------------------------------
// in_     | in  | tdata: radicand, signed fixed point (DATA_WIDTH bits, zero pad)
// out_    | out | tdata: root, unsigned fixed point, 24 bits; tuser: negative_input
//
// Flow: one transaction accepted per clock while the output is not stalled by
//   out_tready; one pipeline stage per two root bits, at Q16.16 and at other widths.
// Reset: rst_n, synchronous, active low; clears stage valid bits only.
// Stalls: each stage holds while its successor is full and blocked; bubbles
//   are squeezed out, so in_tready stays high while any stage is empty.

module fixed_point_square_root_top #(
  parameter int DATA_WIDTH = fpsqrt_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = fpsqrt_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // [DATA_WIDTH-1:0] radicand, rest zero pad
  input  logic [((DATA_WIDTH + 7) / 8) * 8 - 1:0] in_tdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [23:0] root
  output logic [fpsqrt_pkg::ROOT_W-1:0]        out_tdata,
  // [0] negative_input
  output logic                                 out_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready
);

  localparam int BPS  = fpsqrt_pkg::BITS_PER_STAGE;
  // root bits needed for the widened radicand (raw << FRAC_BITS)
  localparam int NBIT = (DATA_WIDTH + FRAC_BITS + 1) / 2;
  localparam int STG  = (NBIT + BPS - 1) / BPS;
  // padded root width and radicand width
  localparam int NP   = STG * BPS;
  localparam int RADW = 2 * NP;
  localparam int REMW = NP + 2;

  // per-stage payload and valid
  logic [RADW-1:0] rad_r [STG];
  logic [REMW-1:0] rem_r [STG];
  logic [NP-1:0]   q_r   [STG];
  logic            neg_r [STG];
  logic [STG-1:0]  vld_r;

  // stage s may load when empty or when its contents move on
  logic [STG:0]    rdy;

  // entry: negative radicands root a zero, which yields zero naturally
  logic                  in_neg;
  logic [RADW-1:0]       in_rad;

  assign in_neg = in_tdata[DATA_WIDTH-1];
  assign in_rad = in_neg ? '0 : (RADW'(in_tdata[DATA_WIDTH-1:0]) << FRAC_BITS);

  assign rdy[STG]  = out_tready;
  assign in_tready = rdy[0];

  genvar s;
  generate
    for (s = 0; s < STG; s++) begin : g_stage
      logic [RADW-1:0] rad_in, rad_nxt;
      logic [REMW-1:0] rem_in, rem_nxt, trial;
      logic [NP-1:0]   q_in, q_nxt;
      logic            neg_in, vld_in;

      if (s == 0) begin : g_first
        assign rad_in = in_rad;
        assign rem_in = '0;
        assign q_in   = '0;
        assign neg_in = in_neg;
        assign vld_in = in_tvalid;
      end else begin : g_next
        assign rad_in = rad_r[s-1];
        assign rem_in = rem_r[s-1];
        assign q_in   = q_r[s-1];
        assign neg_in = neg_r[s-1];
        assign vld_in = vld_r[s-1];
      end

      assign rdy[s] = ~vld_r[s] | rdy[s+1];

      // restoring digit recurrence, BPS root bits
      always_comb begin
        rad_nxt = rad_in;
        rem_nxt = rem_in;
        q_nxt   = q_in;
        trial   = '0;
        for (int j = 0; j < BPS; j++) begin
          rem_nxt = {rem_nxt[REMW-3:0], rad_nxt[RADW-1:RADW-2]};
          trial   = {q_nxt, 2'b01};
          if (rem_nxt >= trial) begin
            rem_nxt = rem_nxt - trial;
            q_nxt   = {q_nxt[NP-2:0], 1'b1};
          end else begin
            q_nxt   = {q_nxt[NP-2:0], 1'b0};
          end
          rad_nxt = {rad_nxt[RADW-3:0], 2'b00};
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[s] <= 1'b0;
        end else if (rdy[s]) begin
          vld_r[s] <= vld_in;
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[s] && vld_in) begin
          rad_r[s] <= rad_nxt;
          rem_r[s] <= rem_nxt;
          q_r[s]   <= q_nxt;
          neg_r[s] <= neg_in;
        end
      end
    end
  endgenerate

  // root wraps to the field width when wider, zero-extends when narrower
  generate
    if (NP >= fpsqrt_pkg::ROOT_W) begin : g_root_trunc
      assign out_tdata = q_r[STG-1][fpsqrt_pkg::ROOT_W-1:0];
    end else begin : g_root_ext
      assign out_tdata = {{(fpsqrt_pkg::ROOT_W - NP){1'b0}}, q_r[STG-1]};
    end
  endgenerate

  assign out_tuser  = neg_r[STG-1];
  assign out_tvalid = vld_r[STG-1];

  // negative input must come out as a zero root
  a_neg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0))
    else $error("negative radicand gave nonzero root");

  // items in flight track accepted minus delivered transactions
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ($countones(vld_r) == $countones($past(vld_r))
      + int'($past(in_tvalid && in_tready)) - int'($past(out_tvalid && out_tready))))
    else $error("pipeline lost or duplicated a transaction");

  // the first stage, when full with its successor blocked, must keep its item
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[0] && !rdy[1]) |=> vld_r[0])
    else $error("first stage dropped a stalled item");

  // the remainder never exceeds twice the partial root
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ({1'b0, rem_r[STG-1]} <= ({2'b00, q_r[STG-1], 1'b0})))
    else $error("square root remainder out of range");

endmodule

[tb/fixed_point_square_root_top_test.sv]
`timescale 1ns / 1ps

// Stream test of the Q16.16 square root pipeline.
// Each radicand transaction accepted on in_ gets one expected root: a typed
// row's own, else a bit-serial floor square root computed here, queued in order.
// Each out_ transaction is checked against the oldest queued root.
module fixed_point_square_root_top_test;

  localparam int DW         = fpsqrt_pkg::DATA_WIDTH_DEF;
  localparam int FB         = fpsqrt_pkg::FRAC_BITS_DEF;
  localparam int ROOT_W     = fpsqrt_pkg::ROOT_W;
  localparam int TDATA_W    = ((DW + 7) / 8) * 8;
  localparam int PROD_W     = DW + FB;
  // pipeline stage count, one stage per two root bits
  localparam int LATENCY    = ((PROD_W + 1) / 2 + 1) / 2;
  localparam int NUM_RANDOM = 900;
  localparam int HOLDOFF    = 100;   // long receiver stall, in cycles
  localparam int IDLE_LIMIT = 4000;  // watchdog: cycles with no transaction
  localparam int MAX_REPORT = 10;

  // one row of stimulus; typed rows carry a hand-written expected result
  typedef struct packed {
    logic [DW-1:0]     radicand;
    logic              typed;
    logic [ROOT_W-1:0] root;
    logic              negative;
  } radicand_row_t;

  // expected root for one accepted radicand
  typedef struct packed {
    logic [DW-1:0]     radicand;
    logic [ROOT_W-1:0] root;
    logic              negative;
  } root_expect_t;

  localparam int NUM_DIRECTED = 19;

  // Directed table: zero, one, exact squares, extremes of both signs,
  // values below one, and odd bit patterns. Rows with typed=0 go through
  // the predictor.
  radicand_row_t directed_rows [NUM_DIRECTED] = '{
    '{32'h0000_0000, 1'b1, 24'h000000, 1'b0},  // zero
    '{32'h0001_0000, 1'b1, 24'h010000, 1'b0},  // 1.0
    '{32'h0004_0000, 1'b1, 24'h020000, 1'b0},  // 4.0 -> 2.0
    '{32'h0000_0001, 1'b1, 24'h000100, 1'b0},  // smallest positive
    '{32'h0000_0100, 1'b1, 24'h001000, 1'b0},
    '{32'h4000_0000, 1'b1, 24'h800000, 1'b0},  // 2^14 -> 2^7
    '{32'h7FFF_FFFF, 1'b1, 24'd11863283, 1'b0}, // largest positive
    '{32'h8000_0000, 1'b1, 24'h000000, 1'b1},  // most negative
    '{32'hFFFF_FFFF, 1'b1, 24'h000000, 1'b1},  // -2^-16
    '{32'hAAAA_AAAA, 1'b1, 24'h000000, 1'b1},
    '{32'hC000_0000, 1'b1, 24'h000000, 1'b1},
    '{32'h0000_FFFF, 1'b0, 24'h000000, 1'b0},  // just below one
    '{32'h0000_8000, 1'b0, 24'h000000, 1'b0},  // 0.5
    '{32'h0000_0002, 1'b0, 24'h000000, 1'b0},
    '{32'h0002_0000, 1'b0, 24'h000000, 1'b0},  // 2.0
    '{32'h0003_0000, 1'b0, 24'h000000, 1'b0},
    '{32'h5555_5555, 1'b0, 24'h000000, 1'b0},
    '{32'h3FFF_FFFF, 1'b0, 24'h000000, 1'b0},
    '{32'h7FFF_0000, 1'b0, 24'h000000, 1'b0}
  };

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic [TDATA_W-1:0] in_tdata   = '0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [ROOT_W-1:0]  out_tdata;
  logic               out_tuser;
  logic               out_tvalid;
  logic               out_tready = 1'b0;

  radicand_row_t radicand_q [$];    // full stimulus, directed then random
  root_expect_t  pending_roots [$]; // roots awaiting their out_ transaction
  int            accept_idx  = 0;
  int            mismatches  = 0;

  always #6 clk = ~clk;

  fixed_point_square_root_top #(
    .DATA_WIDTH(DW),
    .FRAC_BITS (FB)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  // Floor root of radicand * 2^FB, one root bit per iteration from the top.
  // Negative radicands force zero and raise the flag.
  function automatic root_expect_t floor_sqrt_q16(input logic [DW-1:0] radicand);
    root_expect_t      res;
    logic [63:0]       target;
    logic [63:0]       sq;
    logic [ROOT_W-1:0] q;
    logic [ROOT_W-1:0] trial;
    res.radicand = radicand;
    res.negative = radicand[DW-1];
    q = '0;
    if (!radicand[DW-1]) begin
      target = 64'(radicand) << FB;
      for (int b = ROOT_W - 1; b >= 0; b--) begin
        trial = q | (ROOT_W'(1) << b);
        sq    = 64'(trial) * 64'(trial);
        if (sq <= target) q = trial;
      end
    end
    res.root = q;
    return res;
  endfunction

  // Random radicand, weighted toward the interesting regions.
  function automatic logic [DW-1:0] pick_radicand();
    logic [DW-1:0] k;
    case ($urandom_range(0, 9))
      0, 1, 2: return DW'($urandom());
      3, 4:    return DW'($urandom_range(1, 16'hFFFF));     // below one
      5, 6: begin                                         // around a perfect square
        k = DW'($urandom_range(0, 46340));
        return k * k + DW'($urandom_range(0, 2)) - DW'(1);
      end
      7:       return DW'($urandom()) | (DW'(1) << (DW - 1)); // negative
      8:       return DW'(32'h7FFF_FFFF - $urandom_range(0, 1000));
      default: return DW'($urandom_range(0, 255)) << FB;   // whole numbers
    endcase
  endfunction

  task automatic flag_mismatch(input string msg);
    if (mismatches < MAX_REPORT) $display("mismatch @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Sender: walks the stimulus queue in bursts of random length with random
  // gaps. tvalid holds with its data until the transaction is taken.
  always @(posedge clk) begin : sender
    static int issue_idx  = 0;
    static int burst_left = 1;
    static int gap_left   = 0;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) issue_idx++;
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (issue_idx < radicand_q.size()) begin
          in_tvalid <= 1'b1;
          in_tdata  <= TDATA_W'(radicand_q[issue_idx].radicand);
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 48);
            // a quarter of bursts run straight into the next one
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: tready pattern switches between random modes. Twice it holds
  // off for a long stall (HOLDOFF) so the pipeline fills and in_tready drops.
  always @(posedge clk) begin : receiver
    static int rx_cycle  = 0;
    static int rx_mode   = 0;
    static int hold_left = 0;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
      if (rx_cycle == 400 || rx_cycle == 1000) hold_left = HOLDOFF;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       out_tready <= 1'b1;                          // never stalls
          1:       out_tready <= 1'($urandom_range(0, 1));      // coin flip
          2:       out_tready <= ($urandom_range(0, 3) != 0);   // mostly ready
          default: out_tready <= (rx_cycle % 3 == 0);           // sparse, on rx_cycle % 3 == 0
        endcase
      end
    end
  end

  // Monitor: queue a root per accepted radicand, check each out_ transaction
  // against the oldest queued root.
  always @(posedge clk) begin : monitor
    radicand_row_t row;
    root_expect_t  want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        row = radicand_q[accept_idx];
        accept_idx++;
        want = floor_sqrt_q16(in_tdata[DW-1:0]);
        if (row.typed) begin
          want.root     = row.root;
          want.negative = row.negative;
        end
        pending_roots.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        if (pending_roots.size() == 0) begin
          flag_mismatch($sformatf("unexpected root %h neg %b", out_tdata, out_tuser));
        end else begin
          want = pending_roots.pop_front();
          if (out_tdata !== want.root || out_tuser !== want.negative)
            flag_mismatch($sformatf("radicand %h: root %h neg %b, expected %h neg %b",
                                    want.radicand, out_tdata, out_tuser,
                                    want.root, want.negative));
        end
      end
    end
  end

  // Watchdog: a stretch without a transaction on either side that reaches
  // IDLE_LIMIT means the DUT hung.
  always @(posedge clk) begin : watchdog
    static int idle_cycles = 0;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Build the stimulus, release reset, drain, report.
  initial begin : run
    foreach (directed_rows[i]) radicand_q.push_back(directed_rows[i]);
    for (int i = 0; i < NUM_RANDOM; i++)
      radicand_q.push_back(radicand_row_t'{pick_radicand(), 1'b0, '0, 1'b0});

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    wait (accept_idx == radicand_q.size());
    wait (pending_roots.size() == 0);
    // trailing cycles catch any extra result the DUT might still emit
    repeat (2 * LATENCY + 8) @(posedge clk);

    if (mismatches == 0 && pending_roots.size() == 0) begin
      $display("== PASS ==");
    end else begin
      if (pending_roots.size() != 0)
        $display("%0d roots never arrived", pending_roots.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
